### rtl/tlef_pkg.sv
// ----------------------------------------------------------------------------
// tlef_pkg: shared types and constants of the text line ending filter
// Item and result layouts, command format between front and back, codes.
// ----------------------------------------------------------------------------
package tlef_pkg;

  // width of the held space counter before it is clipped to 16 bits
  localparam int SPACE_COUNT_BITS = 16;
  localparam int HELD_W = (SPACE_COUNT_BITS < 16) ? SPACE_COUNT_BITS : 16;
  localparam logic [15:0] SPACE_LIMIT = 16'((17'd1 << HELD_W) - 17'd1);

  // character codes
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // input operations
  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_TEXT      = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_ENDING_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_SPACES      = 2'd1;

  // line ending modes
  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_LF   = 2'd1;
  localparam logic [1:0] MODE_CR   = 2'd2;
  localparam logic [1:0] MODE_CRLF = 2'd3;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // map memory
  localparam int MAP_DEPTH = 256;
  localparam int MAP_WIDTH = 8;

  // what the main result of a command is
  typedef enum logic [1:0] {
    MAIN_MAPPED,
    MAIN_CR,
    MAIN_LF,
    MAIN_CRLF
  } main_kind_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] map_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] repeat_count;
    logic        spaces_saturated;
    logic        last;
  } out_item_t;

  // one classified text byte: optional space run, then the main result
  typedef struct packed {
    logic        run_valid;
    logic [15:0] run_count;
    logic        run_sat;
    main_kind_t  main_kind;
    logic [7:0]  mapped_byte;
  } cmd_t;

endpackage

### rtl/text_line_ending_filter.sv
// ----------------------------------------------------------------------------
// text_line_ending_filter: line ending canonicalizing byte filter
// Maps text bytes through a loadable table, rewrites line ends and strips
// trailing spaces, reporting held spaces as one run result.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_item_t (operation, index, byte)
//   out      output     out_valid/out_stall out_item_t (byte, count, flags)
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// One input item per cycle while in_stall is low; an item with two results
// holds the output for two transfers, so the sustained rate is one result
// per cycle while out_stall is low. Results pass the map read, then the queue.
// Reset clears config, held state and the queue; the map is not cleared.
// Input stalls only when the lookup stage cannot move into a full queue.
// ----------------------------------------------------------------------------
module text_line_ending_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tlef_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tlef_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [tlef_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlef_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlef_pkg::*;

  logic push;
  logic push_ready;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // intake, classification and map lookup
  tlef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // command queue
  tlef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // result sequencing
  tlef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### rtl/tlef_ram.sv
// ----------------------------------------------------------------------------
// tlef_ram: generic single port write, single port read memory
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module tlef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tlef_front.sv
// ----------------------------------------------------------------------------
// tlef_front: item intake and classification
// Holds the config, the space counter and the CR flag, loads the map and
// looks up text bytes, and hands one command per emitting byte to the queue.
// ----------------------------------------------------------------------------
module tlef_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tlef_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [tlef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlef_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              push,
  output tlef_pkg::cmd_t                    push_cmd,
  input  logic                              push_ready
);
  import tlef_pkg::*;

  logic [1:0]        line_ending_mode;
  logic              strip_trailing_spaces;
  logic [HELD_W-1:0] held_spaces;
  logic [HELD_W-1:0] held_spaces_next;
  logic              held_overflow;
  logic              held_overflow_next;
  logic              drop_next_lf;
  logic              drop_next_lf_next;
  logic              s1_valid;
  cmd_t              s1_cmd;
  cmd_t              cmd_new;
  logic              emit;
  logic              accept;
  logic              text_acc;
  logic              map_we;
  logic              is_lf;
  logic              is_cr;
  logic              is_sp;
  logic [7:0]        map_rdata;

  // handshake: the lookup stage must be free or moving on
  assign push     = s1_valid && push_ready;
  assign in_stall = s1_valid && !push_ready;
  assign accept   = in_valid && !in_stall;
  assign text_acc = accept && (in_data.operation == OP_TEXT);
  assign map_we   = accept && (in_data.operation == OP_MAP_WRITE);

  assign is_lf = (in_data.data_byte == CH_LF);
  assign is_cr = (in_data.data_byte == CH_CR);
  assign is_sp = (in_data.data_byte == CH_SP);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_ending_mode      <= MODE_KEEP;
      strip_trailing_spaces <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_ENDING_MODE: line_ending_mode      <= cfg_data[1:0];
        CFG_STRIP_SPACES:     strip_trailing_spaces <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify a text byte and update the held state
  always_comb begin
    emit               = 1'b0;
    cmd_new.run_valid  = 1'b0;
    cmd_new.run_count  = 16'(held_spaces);
    cmd_new.run_sat    = held_overflow;
    cmd_new.main_kind  = MAIN_MAPPED;
    cmd_new.mapped_byte = '0;
    held_spaces_next   = held_spaces;
    held_overflow_next = held_overflow;
    drop_next_lf_next  = drop_next_lf;
    if (text_acc) begin
      drop_next_lf_next = 1'b0;
      if (drop_next_lf && is_lf) begin
        // lf right after a converted cr is swallowed
      end else if (is_lf || is_cr) begin
        held_spaces_next   = '0;
        held_overflow_next = 1'b0;
        emit               = 1'b1;
        case (line_ending_mode)
          MODE_LF:   cmd_new.main_kind = MAIN_LF;
          MODE_CR:   cmd_new.main_kind = MAIN_CR;
          MODE_CRLF: cmd_new.main_kind = MAIN_CRLF;
          default:   cmd_new.main_kind = MAIN_MAPPED;
        endcase
        if (line_ending_mode != MODE_KEEP) begin
          drop_next_lf_next = is_cr;
        end
      end else if (strip_trailing_spaces && is_sp) begin
        // saturating space count
        if (held_spaces == {HELD_W{1'b1}}) begin
          held_overflow_next = 1'b1;
        end else begin
          held_spaces_next = held_spaces + 1'b1;
        end
      end else begin
        emit               = 1'b1;
        cmd_new.run_valid  = (held_spaces != '0);
        held_spaces_next   = '0;
        held_overflow_next = 1'b0;
      end
    end
  end

  // held state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_spaces   <= '0;
      held_overflow <= 1'b0;
      drop_next_lf  <= 1'b0;
    end else begin
      held_spaces   <= held_spaces_next;
      held_overflow <= held_overflow_next;
      drop_next_lf  <= drop_next_lf_next;
    end
  end

  // lookup stage, lined up with the map read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_cmd <= cmd_new;
    end
  end

  // character map
  tlef_ram #(
    .WIDTH (MAP_WIDTH),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_data.map_index),
    .wdata (in_data.data_byte),
    .re    (text_acc),
    .raddr (in_data.data_byte),
    .rdata (map_rdata)
  );

  // command toward the queue carries the looked up byte
  always_comb begin
    push_cmd             = s1_cmd;
    push_cmd.mapped_byte = map_rdata;
  end

endmodule

### rtl/tlef_queue.sv
// ----------------------------------------------------------------------------
// tlef_queue: short command queue between front and back
// Register based fifo; a push is taken while full if the head leaves.
// ----------------------------------------------------------------------------
module tlef_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlef_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           head_valid,
  output tlef_pkg::cmd_t head_cmd,
  input  logic           pop
);
  import tlef_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH)) || pop;
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/tlef_back.sv
// ----------------------------------------------------------------------------
// tlef_back: result sequencer
// Expands the head command into one or two results, one per transfer.
// ----------------------------------------------------------------------------
module tlef_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  tlef_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tlef_pkg::out_item_t out_data
);
  import tlef_pkg::*;

  logic phase;
  logic two_results;
  logic xfer;

  assign two_results = head_cmd.run_valid || (head_cmd.main_kind == MAIN_CRLF);
  assign out_valid   = head_valid;
  assign xfer        = out_valid && !out_stall;
  assign pop         = xfer && out_data.last;

  // result selection by phase
  always_comb begin
    out_data.out_byte         = head_cmd.mapped_byte;
    out_data.repeat_count     = 16'd1;
    out_data.spaces_saturated = 1'b0;
    out_data.last             = 1'b1;
    if (!phase) begin
      out_data.last = !two_results;
      if (head_cmd.run_valid) begin
        out_data.out_byte         = CH_SP;
        out_data.repeat_count     = head_cmd.run_count;
        out_data.spaces_saturated = head_cmd.run_sat;
      end else begin
        case (head_cmd.main_kind)
          MAIN_CR:   out_data.out_byte = CH_CR;
          MAIN_LF:   out_data.out_byte = CH_LF;
          MAIN_CRLF: out_data.out_byte = CH_CR;
          default:   out_data.out_byte = head_cmd.mapped_byte;
        endcase
      end
    end else if (!head_cmd.run_valid) begin
      // second half of cr lf
      out_data.out_byte = CH_LF;
    end
  end

  // phase within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (xfer) begin
      phase <= !out_data.last;
    end
  end

endmodule

### rtl/tlef_checker.sv
// ----------------------------------------------------------------------------
// tlef_checker: port level checks of the text line ending filter
// Watches the output channel for result format, stall hold and reset behavior.
// ----------------------------------------------------------------------------
module tlef_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input tlef_pkg::out_item_t out_data
);
  import tlef_pkg::*;

  // stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output result changed while stalled");

  // a repeated result is a space run and is never the final one of its item
  a_run_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.repeat_count != 16'd1) |->
      (out_data.out_byte == CH_SP) && !out_data.last)
    else $error("repeat count on a result that is not a space run");

  // a saturated run carries the full count
  a_sat_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.spaces_saturated |-> out_data.repeat_count == SPACE_LIMIT)
    else $error("saturation flag without a full space count");

  // no result ever has a zero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.repeat_count != 16'd0)
    else $error("result with zero repeat count");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind text_line_ending_filter tlef_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
